// ===== design/f8dq_pkg.sv =====
// types and constants shared by the fp8 e4m3 scaled dequantizer
`timescale 1ns / 1ps
package f8dq_pkg;

	// output encodings selected by the format register
	localparam logic [1:0] FMT_F32  = 2'd0;
	localparam logic [1:0] FMT_F16  = 2'd1;
	localparam logic [1:0] FMT_BF16 = 2'd2;
	// unused encoding, behaves as float32
	localparam logic [1:0] FMT_RSVD = 2'd3;

	// canonical quiet nans
	localparam logic [31:0] QNAN_F32  = 32'h7fc0_0000;
	localparam logic [31:0] QNAN_F16  = 32'h0000_7e00;
	localparam logic [31:0] QNAN_BF16 = 32'h0000_7fc0;

	// e4m3fn code fields
	localparam logic [3:0] E4M3_EXP_MAX = 4'hf;
	localparam logic [2:0] E4M3_MAN_NAN = 3'h7;

	typedef struct packed {
		logic [7:0]  q_byte;
		logic [31:0] scale_bits;
	} in_item_t;

	typedef struct packed {
		logic [31:0] result_bits;
		logic        is_nan;
	} out_item_t;

endpackage

// ===== design/fp8_e4m3_scaled_dequantize.sv =====
// top level of the fp8 e4m3fn block-scaled dequantizer
`timescale 1ns / 1ps
// fp8 e4m3fn scaled dequantizer
//
// in channel: in_valid / in_stall / in_data carry one fp8 code and the float32
// scale of its block. a request is taken on a rising edge with in_valid high
// and in_stall low. out channel: out_valid / out_stall / out_data carry the
// encoded result and a nan flag, taken the same way.
// cfg channel: cfg_valid / cfg_ready / cfg_data write the 2-bit output format
// (0 float32, 1 float16, 2 bfloat16, 3 behaves as float32). cfg_ready is
// always high; write it only while the pipe is empty.
//
// four register stages: input, normalized product, float32 rounding, output.
// a result moves through the product, rounding and output registers to
// out_valid; a new request is taken every cycle, one per clock sustained.
// the whole pipe advances together; it holds only while the output register
// is full and out_stall is high, and then in_stall is high too.
// reset empties all stages and sets the format to float32.
module fp8_e4m3_scaled_dequantize (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  f8dq_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output f8dq_pkg::out_item_t  out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_data
);
	import f8dq_pkg::*;

	// pipe advance: everything moves unless the output is held
	logic adv;
	logic [1:0] fmt_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	in_item_t item_s1;

	// stage 2 registers: normalized product
	logic              sign_s2, nan_s2, inf_s2, zero_s2;
	logic [27:0]       norm_s2;
	logic signed [9:0] bexp_s2;

	// stage 3 registers: float32 product
	logic [31:0] f32_s3;
	logic        nan_s3;

	out_item_t res_s4;

	assign adv       = !(valid_s4 && out_stall);
	assign in_stall  = !adv;
	assign cfg_ready = 1'b1;
	assign out_valid = valid_s4;
	assign out_data  = res_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_F32;
		end else if (cfg_valid && cfg_ready) begin
			fmt_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= in_data;
		end
	end

	// ---------------- stage 2: decode, multiply, normalize ----------------
	function automatic logic [4:0] lzc28(input logic [27:0] v);
		logic [4:0] n;
		n = 5'd0;
		for (int i = 0; i < 28; i++) begin
			if (v[i]) n = 5'(27 - i);
		end
		return n;
	endfunction

	logic [3:0]        e8;
	logic [2:0]        m8;
	logic [3:0]        sig8;
	logic [7:0]        es;
	logic [22:0]       ms;
	logic [23:0]       sigs;
	logic signed [9:0] exp8, exps, bexp_d;
	logic [27:0]       prod, norm_d;
	logic [4:0]        lz;
	logic              nan_d, inf_d, zero_d;

	always_comb begin
		e8   = item_s1.q_byte[6:3];
		m8   = item_s1.q_byte[2:0];
		es   = item_s1.scale_bits[30:23];
		ms   = item_s1.scale_bits[22:0];
		sig8 = {(e8 != 4'd0), m8};
		sigs = {(es != 8'd0), ms};
		exp8 = (e8 == 4'd0) ? -10'sd9 : $signed({6'd0, e8}) - 10'sd10;
		exps = (es == 8'd0) ? -10'sd149 : $signed({2'd0, es}) - 10'sd150;
		prod = 28'(sig8) * 28'(sigs);
		lz   = lzc28(prod);
		norm_d = prod << lz;
		// biased float32 exponent of the leading one
		bexp_d = exp8 + exps + 10'sd154 - $signed({5'd0, lz});
		zero_d = (sig8 == 4'd0) || (sigs == 24'd0);
		nan_d  = (e8 == E4M3_EXP_MAX && m8 == E4M3_MAN_NAN)
			|| (es == 8'hff && ms != 23'd0)
			|| (es == 8'hff && sig8 == 4'd0);
		inf_d  = (es == 8'hff) && !nan_d;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sign_s2 <= item_s1.q_byte[7] ^ item_s1.scale_bits[31];
			nan_s2  <= nan_d;
			inf_s2  <= inf_d;
			zero_s2 <= zero_d;
			norm_s2 <= norm_d;
			bexp_s2 <= bexp_d;
		end
	end

	// ---------------- stage 3: round to float32 ----------------
	logic signed [9:0] sh_t;
	logic [4:0]        sh;
	logic [59:0]       x32;
	logic [24:0]       q32, qr32;
	logic [9:0]        ebase32, etot32;
	logic [31:0]       f32_d;

	always_comb begin
		// subnormal results shift further right
		sh_t = 10'sd5 - bexp_s2;
		if (bexp_s2 > 10'sd0) begin
			sh = 5'd4;
		end else if (sh_t > 10'sd31) begin
			sh = 5'd31;
		end else begin
			sh = sh_t[4:0];
		end
		x32  = {norm_s2, 32'd0} >> sh;
		q32  = x32[56:32];
		qr32 = q32 + 25'(x32[31] & ((|x32[30:0]) | q32[0]));
		ebase32 = (bexp_s2 > 10'sd0) ? 10'(bexp_s2 - 10'sd1) : 10'd0;
		// the hidden bit and any rounding carry land in the exponent
		etot32  = ebase32 + {8'd0, qr32[24:23]};
		if (inf_s2 || nan_s2) begin
			f32_d = {sign_s2, 8'hff, 23'd0};
		end else if (zero_s2) begin
			f32_d = {sign_s2, 31'd0};
		end else if (etot32 >= 10'd255) begin
			f32_d = {sign_s2, 8'hff, 23'd0};
		end else begin
			f32_d = {sign_s2, etot32[7:0], qr32[22:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f32_s3 <= f32_d;
			nan_s3 <= nan_s2;
		end
	end

	// ---------------- stage 4: output encoding ----------------
	logic              fs;
	logic [7:0]        fe;
	logic [22:0]       fm;
	logic signed [9:0] b16, sh16_t;
	logic [4:0]        sh16;
	logic [55:0]       x16;
	logic [11:0]       q16, qr16;
	logic [9:0]        ebase16, etot16;
	logic [15:0]       h16, bf16;
	out_item_t         res_d;

	always_comb begin
		fs = f32_s3[31];
		fe = f32_s3[30:23];
		fm = f32_s3[22:0];
		b16    = $signed({2'd0, fe}) - 10'sd112;
		sh16_t = 10'sd14 - b16;
		if (b16 > 10'sd0) begin
			sh16 = 5'd13;
		end else if (sh16_t > 10'sd31) begin
			sh16 = 5'd31;
		end else begin
			sh16 = sh16_t[4:0];
		end
		x16  = {1'b1, fm, 32'd0} >> sh16;
		q16  = x16[43:32];
		qr16 = q16 + 12'(x16[31] & ((|x16[30:0]) | q16[0]));
		ebase16 = (b16 > 10'sd0) ? 10'(b16 - 10'sd1) : 10'd0;
		etot16  = ebase16 + {8'd0, qr16[11:10]};
		// float32 subnormals are far below the half-precision range
		if (fe == 8'hff) begin
			h16 = {fs, 5'h1f, 10'd0};
		end else if (fe == 8'd0) begin
			h16 = {fs, 15'd0};
		end else if (etot16 >= 10'd31) begin
			h16 = {fs, 5'h1f, 10'd0};
		end else begin
			h16 = {fs, etot16[4:0], qr16[9:0]};
		end

		// bfloat16 is the upper half rounded; carries run into the exponent
		bf16 = f32_s3[31:16]
			+ 16'(f32_s3[15] & ((|f32_s3[14:0]) | f32_s3[16]));

		res_d.is_nan = nan_s3;
		unique case (fmt_q)
			FMT_F16: begin
				res_d.result_bits = nan_s3 ? QNAN_F16 : {16'd0, h16};
			end
			FMT_BF16: begin
				res_d.result_bits = nan_s3 ? QNAN_BF16 : {16'd0, bf16};
			end
			default: begin
				res_d.result_bits = nan_s3 ? QNAN_F32 : f32_s3;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s4 <= res_d;
		end
	end

	// ---------------- checks ----------------
	a_nan_canonical: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.is_nan |->
			(out_data.result_bits == QNAN_F32) || (out_data.result_bits == QNAN_F16)
			|| (out_data.result_bits == QNAN_BF16))
		else $error("nan result not canonical");

	a_half_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((fmt_q == FMT_F16) || (fmt_q == FMT_BF16)) |->
			out_data.result_bits[31:16] == 16'd0)
		else $error("16-bit result has upper bits set");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held output");

	a_pipe_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall && valid_s3 |=> out_valid)
		else $error("result lost between float32 and output stage");

endmodule

// ===== tb/sv/tb_fp8_e4m3_scaled_dequantize.sv =====
// testbench for the fp8 e4m3fn block-scaled dequantizer
`timescale 1ns / 1ps
module tb_fp8_e4m3_scaled_dequantize;
	import f8dq_pkg::*;

	// expected results of the dequantizer, predicted per accepted request
	class dequant_scoreboard;
		out_item_t pending[$];
		int        errors;

		function new();
			errors = 0;
		endfunction

		// round sign * sig * 2^exp2 to a float with ebits/mbits, nearest even
		function logic [31:0] round_to(logic sign, longint unsigned sig, int exp2,
			int ebits, int mbits);
			int bias;
			int maxf;
			int p;
			int sh;
			int subsh;
			int biased;
			longint unsigned q;
			longint unsigned rem;
			longint unsigned half;
			logic [31:0] sb;
			bias = (1 << (ebits - 1)) - 1;
			maxf = (1 << ebits) - 1;
			p = 0;
			sb = 32'(sign) << (ebits + mbits);
			while (p < 63 && (sig >> (p + 1)) != 0) p++;
			sh = p - mbits;
			subsh = 1 - bias - mbits - exp2;
			if (subsh > sh) sh = subsh;
			if (sh > 50) return sb;
			if (sh > 0) begin
				rem = sig & ((64'd1 << sh) - 64'd1);
				half = 64'd1 << (sh - 1);
				q = sig >> sh;
				if (rem > half || (rem == half && q[0])) q++;
			end else begin
				q = sig << (-sh);
			end
			if ((q >> (mbits + 1)) != 0) begin
				q = q >> 1;
				sh++;
			end
			if (q < (64'd1 << mbits)) return sb | q[31:0];
			biased = exp2 + sh + mbits + bias;
			if (biased >= maxf) return sb | (32'(maxf) << mbits);
			q = q - (64'd1 << mbits);
			return sb | (32'(biased) << mbits) | q[31:0];
		endfunction

		function out_item_t dequantize(in_item_t r, logic [1:0] fmt);
			out_item_t       o;
			logic [3:0]      e8;
			logic [2:0]      m8;
			logic [7:0]      es;
			logic [22:0]     ms;
			logic            sign;
			longint unsigned sig8;
			longint unsigned sigs;
			int              exp8;
			int              exps;
			logic            nan;
			logic [31:0]     f32;
			int              eb;
			int              mb;
			e8 = r.q_byte[6:3];
			m8 = r.q_byte[2:0];
			es = r.scale_bits[30:23];
			ms = r.scale_bits[22:0];
			sign = r.q_byte[7] ^ r.scale_bits[31];
			nan = 1'b0;
			f32 = '0;
			if (e8 == 0) begin
				sig8 = 64'(m8);
				exp8 = -9;
			end else begin
				sig8 = 64'({1'b1, m8});
				exp8 = int'(e8) - 10;
			end
			if (es == 0) begin
				sigs = 64'(ms);
				exps = -149;
			end else begin
				sigs = 64'({1'b1, ms});
				exps = int'(es) - 150;
			end
			if ((e8 == E4M3_EXP_MAX && m8 == E4M3_MAN_NAN) || (es == 8'hff && ms != 0)) begin
				nan = 1'b1;
			end else if (es == 8'hff) begin
				if (sig8 == 0) nan = 1'b1;
				else f32 = {sign, 8'hff, 23'd0};
			end else if (sig8 == 0 || sigs == 0) begin
				f32 = {sign, 31'd0};
			end else begin
				f32 = round_to(sign, sig8 * sigs, exp8 + exps, 8, 23);
			end
			o.is_nan = nan;
			if (nan) begin
				o.result_bits = (fmt == FMT_F16) ? QNAN_F16 :
					(fmt == FMT_BF16) ? QNAN_BF16 : QNAN_F32;
			end else if (fmt != FMT_F16 && fmt != FMT_BF16) begin
				o.result_bits = f32;
			end else begin
				eb = (fmt == FMT_F16) ? 5 : 8;
				mb = (fmt == FMT_F16) ? 10 : 7;
				if (f32[30:23] == 8'hff)
					o.result_bits = (32'(f32[31]) << (eb + mb)) | (((32'd1 << eb) - 1) << mb);
				else if (f32[30:0] == 0)
					o.result_bits = 32'(f32[31]) << (eb + mb);
				else if (f32[30:23] == 0)
					o.result_bits = round_to(f32[31], 64'(f32[22:0]), -149, eb, mb);
				else
					o.result_bits = round_to(f32[31], 64'({1'b1, f32[22:0]}),
						int'(f32[30:23]) - 150, eb, mb);
			end
			return o;
		endfunction

		function void note_request(in_item_t r, logic [1:0] fmt);
			pending.push_back(dequantize(r, fmt));
		endfunction

		function void check_output(out_item_t got);
			out_item_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h / nan %b", $time, got.result_bits, got.is_nan);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.result_bits !== want.result_bits) begin
				$display("%0t: result_bits expected %h actual %h", $time,
					want.result_bits, got.result_bits);
				errors++;
			end
			if (got.is_nan !== want.is_nan) begin
				$display("%0t: is_nan expected %b actual %b", $time, want.is_nan, got.is_nan);
				errors++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	in_item_t   in_data;
	logic       out_valid;
	logic       out_stall;
	out_item_t  out_data;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_data;

	dequant_scoreboard sb;
	logic [1:0] fmt_now;      // format the block currently holds
	int         send_gap_pct; // percent chance the sender idles on a given clock
	int         stall_pct;    // percent chance the receiver stalls on a given clock
	bit         hold_req;     // asks the receiver for one long hold-off

	fp8_e4m3_scaled_dequantize u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// both handshakes are sampled on the edge, before any nba lands
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) sb.note_request(in_data, fmt_now);
			if (out_valid && !out_stall) sb.check_output(out_data);
		end
	end

	// receiver: random stalls, plus a long hold-off when asked
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				repeat (300) begin
					out_stall <= 1'b1;
					@(posedge clk);
				end
			end
			out_stall <= (stall_pct > 0 && $urandom_range(99) < stall_pct);
		end
	end

	// generous cap on the whole run
	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// offer one request, idling first at random, and wait until it is taken
	task automatic send_request(logic [7:0] q, logic [31:0] scale);
		while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{q_byte: q, scale_bits: scale};
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// lower valid and let the pipe drain completely
	task automatic drain_pipe();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// format writes happen only with the pipe empty
	task automatic write_format(logic [1:0] f);
		cfg_valid <= 1'b1;
		cfg_data <= f;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		fmt_now = f;
	endtask

	// scale patterns biased toward specials and rounding/overflow edges
	function automatic logic [31:0] pick_scale();
		logic [31:0] s;
		s = $urandom;
		case ($urandom_range(6))
			0: ;
			1: s[30:23] = 8'($urandom_range(100, 150));  // f16 range edges
			2: begin                                     // inf / nan
				s[30:23] = 8'hff;
				if ($urandom_range(1)) s[22:0] = '0;
			end
			3: begin                                     // zero / subnormal
				s[30:23] = 8'h00;
				if ($urandom_range(1)) s[22:0] = '0;
			end
			4: s[30:23] = 8'($urandom_range(1, 24));     // f32 underflow
			5: s[30:23] = 8'($urandom_range(230, 254));  // f32 overflow
			default: s[30:0] = 31'h3f80_0000 | 31'($urandom_range(7));
		endcase
		return s;
	endfunction

	function automatic logic [7:0] pick_code();
		case ($urandom_range(7))
			0: return {1'($urandom), E4M3_EXP_MAX, E4M3_MAN_NAN};
			1: return {1'($urandom), 7'd0};
			2: return {1'($urandom), 4'd0, 3'($urandom)};
			default: return 8'($urandom);
		endcase
	endfunction

	logic [7:0]  dir_code[10]  = '{8'h00, 8'h80, 8'h7f, 8'hff, 8'h7e, 8'hfe, 8'h01,
		8'h08, 8'h07, 8'h38};
	logic [31:0] dir_scale[10] = '{32'h3f80_0000, 32'hbf80_0000, 32'h7f80_0000,
		32'hff80_0000, 32'h7fc0_0001, 32'h0000_0000, 32'h8000_0000, 32'h0000_0001,
		32'h7f7f_ffff, 32'h0080_0000};
	logic [1:0]  phase_fmt[8]  = '{FMT_F32, FMT_F16, FMT_BF16, FMT_RSVD, FMT_F16,
		FMT_BF16, FMT_F32, FMT_F16};

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		fmt_now = FMT_F32;
		send_gap_pct = 0;
		stall_pct = 0;
		hold_req = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: code extremes paired against special scale classes
		for (int i = 0; i < 10; i++) send_request(dir_code[i], dir_scale[i]);
		for (int i = 0; i < 10; i++) send_request(dir_code[i], dir_scale[(i + 3) % 10]);
		send_request(8'h7e, 32'h7f00_0000);   // f32 overflow to infinity
		send_request(8'h01, 32'h0000_0003);   // deep underflow to zero
		send_request(8'h7e, 32'h4780_0000);   // product above the f16 range, checked as float32
		drain_pipe();

		for (int p = 0; p < 8; p++) begin
			write_format(phase_fmt[p]);
			case (p % 4)
				0: begin send_gap_pct = 0;  stall_pct = 0;  end
				1: begin send_gap_pct = 88; stall_pct = 0;  end
				2: begin send_gap_pct = 0;  stall_pct = 88; end
				default: begin send_gap_pct = 36; stall_pct = 36; end
			endcase
			// long receiver hold-off while requests keep coming, fills the pipe
			if (p == 0) hold_req = 1'b1;
			for (int n = 0; n < 105; n++) send_request(pick_code(), pick_scale());
			// sender pauses here until every result is back
			drain_pipe();
		end
		send_gap_pct = 0;
		stall_pct = 0;
		write_format(FMT_F32);
		drain_pipe();

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
